FILE: rtl/scb_pkg.sv
// types and constants shared by the scope column envelope binner
package scb_pkg;

   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_READ   = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [2:0] REG_WINDOW_LEFT  = 3'd0;
   localparam logic [2:0] REG_WINDOW_RIGHT = 3'd1;
   localparam logic [2:0] REG_COLUMN_SCALE = 3'd2;
   localparam logic [2:0] REG_SCREEN_ROWS  = 3'd3;
   localparam logic [2:0] REG_SCREEN_COLS  = 3'd4;
   localparam logic [2:0] REG_CHAN_ENABLE  = 3'd5;
   localparam logic [2:0] REG_GAINS        = 3'd6;
   localparam logic [2:0] REG_OFFSETS      = 3'd7;

   localparam int PORT_LANES = 4;

   typedef struct packed {
      logic [1:0]         mode;
      logic [31:0]        sample_time;
      logic [2:0]         value_count;
      logic signed [15:0] sample_ch0;
      logic signed [15:0] sample_ch1;
      logic signed [15:0] sample_ch2;
      logic signed [15:0] sample_ch3;
      logic [7:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [7:0] column_echo;
      logic [3:0] occupied_mask;
      logic [7:0] min_row_ch0;
      logic [7:0] max_row_ch0;
      logic [7:0] min_row_ch1;
      logic [7:0] max_row_ch1;
      logic [7:0] min_row_ch2;
      logic [7:0] max_row_ch2;
      logic [7:0] min_row_ch3;
      logic [7:0] max_row_ch3;
   } rsp_type;

   // step strobes from the sequencer to the column mapper and the lanes
   typedef struct packed {
      logic map1;
      logic map2;
      logic map3;
      logic map4;
      logic update;
      logic fetch;
      logic clear;
   } lane_ctl_type;

endpackage

FILE: rtl/scope_column_envelope_binner_top.sv
// top level: sequencer, configuration registers, lanes and result merge
//
// Four-channel scope envelope binner. A request is taken when start is high
// and busy is low; busy then stays high until the request is done. A sample
// request keeps busy high through two multiply stages for the column and
// the lane scaling, the row divide, then one read-modify-write of each
// lane's min/max memory. A read request passes the read and reply states;
// its result shows on rsp_data with rsp_valid for one cycle, set after the
// reply state; the result cannot be held off and must be taken then.
// A clear uses ST_CLEAR; mode 3 stays idle. Configuration writes on
// the csr port take effect at once and belong in periods when busy is low.
module scope_column_envelope_binner_top #(
   parameter int MAX_COLUMNS = 256,
   parameter int CHANNELS    = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  scb_pkg::req_type req_data,
   output logic             rsp_valid,
   output scb_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   import scb_pkg::*;

   localparam int AW    = $clog2(MAX_COLUMNS);
   localparam int LANES = (CHANNELS < PORT_LANES) ? CHANNELS : PORT_LANES;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP1,
      ST_MAP2,
      ST_MAP3,
      ST_MAP4,
      ST_UPDATE,
      ST_READ,
      ST_REPLY,
      ST_CLEAR
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] window_left_ff, window_right_ff, column_scale_ff;
   logic [7:0]  screen_rows_ff, screen_cols_ff;
   logic [3:0]  chan_enable_ff;
   logic [63:0] gains_ff, offsets_ff;

   req_type      req_ff;
   rsp_type      rsp_ff, rsp_in;
   logic         rsp_valid_ff;
   lane_ctl_type ctl;
   logic         accept;

   logic [AW-1:0] col_addr, lane_addr;
   logic          col_ok;
   logic [10:0]   rd_idx11;
   logic          rd_in_range;

   logic signed [15:0] samp [PORT_LANES];
   logic [PORT_LANES-1:0] lane_valid;
   logic [7:0]            lane_min [PORT_LANES];
   logic [7:0]            lane_max [PORT_LANES];
   logic [3:0]            occ;

   assign accept = start && (state_ff == ST_IDLE);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_left_ff  <= 32'h0000_0000;
         window_right_ff <= 32'hFFFF_FFFF;
         column_scale_ff <= 32'h0001_0000;
         screen_rows_ff  <= 8'd22;
         screen_cols_ff  <= 8'd80;
         chan_enable_ff  <= 4'hF;
         gains_ff        <= 64'h1000_1000_1000_1000;
         offsets_ff      <= 64'h0;
      end else if (csr_we) begin
         case (csr_index)
            REG_WINDOW_LEFT:  window_left_ff  <= csr_wdata[31:0];
            REG_WINDOW_RIGHT: window_right_ff <= csr_wdata[31:0];
            REG_COLUMN_SCALE: column_scale_ff <= csr_wdata[31:0];
            REG_SCREEN_ROWS:  screen_rows_ff  <= csr_wdata[7:0];
            REG_SCREEN_COLS:  screen_cols_ff  <= csr_wdata[7:0];
            REG_CHAN_ENABLE:  chan_enable_ff  <= csr_wdata[3:0];
            REG_GAINS:        gains_ff        <= csr_wdata;
            REG_OFFSETS:      offsets_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.mode)
                  MODE_SAMPLE: state_in = ST_MAP1;
                  MODE_READ:   state_in = ST_READ;
                  MODE_CLEAR:  state_in = ST_CLEAR;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_MAP1:   state_in = ST_MAP2;
         ST_MAP2:   state_in = ST_MAP3;
         ST_MAP3:   state_in = ST_MAP4;
         ST_MAP4:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         ST_READ:   state_in = ST_REPLY;
         ST_REPLY:  state_in = ST_IDLE;
         ST_CLEAR:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl.map1   = (state_ff == ST_MAP1);
      ctl.map2   = (state_ff == ST_MAP2);
      ctl.map3   = (state_ff == ST_MAP3);
      ctl.map4   = (state_ff == ST_MAP4);
      ctl.update = (state_ff == ST_UPDATE);
      ctl.fetch  = (state_ff == ST_MAP3) || (state_ff == ST_READ);
      ctl.clear  = (state_ff == ST_CLEAR);
   end

   always_comb begin
      rd_idx11    = {3'b000, req_ff.read_index};
      rd_in_range = rd_idx11 < 11'(MAX_COLUMNS);
      lane_addr   = (state_ff == ST_READ) ? rd_idx11[AW-1:0] : col_addr;
      samp[0]     = req_ff.sample_ch0;
      samp[1]     = req_ff.sample_ch1;
      samp[2]     = req_ff.sample_ch2;
      samp[3]     = req_ff.sample_ch3;
   end

   scb_column #(
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_column (
      .clock       (clock),
      .ctl         (ctl),
      .sample_time (req_ff.sample_time),
      .window_left (window_left_ff),
      .window_right(window_right_ff),
      .column_scale(column_scale_ff),
      .screen_cols (screen_cols_ff),
      .col_addr    (col_addr),
      .col_ok      (col_ok)
   );

   for (genvar c = 0; c < PORT_LANES; c++) begin : g_lane
      if (c < LANES) begin : g_on
         logic active;
         assign active = chan_enable_ff[c] && (req_ff.value_count > 3'(c));
         scb_lane #(
            .MAX_COLUMNS(MAX_COLUMNS),
            .CHANNELS   (CHANNELS),
            .LANE       (c)
         ) u_lane (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .sample     (samp[c]),
            .gain       (gains_ff[16*c +: 16]),
            .offset     ($signed(offsets_ff[16*c +: 16])),
            .screen_rows(screen_rows_ff),
            .active     (active),
            .col_addr   (lane_addr),
            .col_ok     (col_ok),
            .rd_valid   (lane_valid[c]),
            .rd_min     (lane_min[c]),
            .rd_max     (lane_max[c])
         );
      end else begin : g_off
         assign lane_valid[c] = 1'b0;
         assign lane_min[c]   = 8'd0;
         assign lane_max[c]   = 8'd0;
      end
   end

   // merge the lanes into one result
   always_comb begin
      occ = rd_in_range ? lane_valid : 4'h0;
      rsp_in.column_echo   = req_ff.read_index;
      rsp_in.occupied_mask = occ;
      rsp_in.min_row_ch0   = occ[0] ? lane_min[0] : 8'd0;
      rsp_in.max_row_ch0   = occ[0] ? lane_max[0] : 8'd0;
      rsp_in.min_row_ch1   = occ[1] ? lane_min[1] : 8'd0;
      rsp_in.max_row_ch1   = occ[1] ? lane_max[1] : 8'd0;
      rsp_in.min_row_ch2   = occ[2] ? lane_min[2] : 8'd0;
      rsp_in.max_row_ch2   = occ[2] ? lane_max[2] : 8'd0;
      rsp_in.min_row_ch3   = occ[3] ? lane_min[3] : 8'd0;
      rsp_in.max_row_ch3   = occ[3] ? lane_max[3] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_REPLY);
         if (state_ff == ST_REPLY) begin
            rsp_ff <= rsp_in;
         end
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/scb_column.sv
// time to screen column mapping with window and range checks
module scb_column #(
   parameter int MAX_COLUMNS = 256
) (
   input  logic                          clock,
   input  scb_pkg::lane_ctl_type         ctl,
   input  logic [31:0]                   sample_time,
   input  logic [31:0]                   window_left,
   input  logic [31:0]                   window_right,
   input  logic [31:0]                   column_scale,
   input  logic [7:0]                    screen_cols,
   output logic [$clog2(MAX_COLUMNS)-1:0] col_addr,
   output logic                          col_ok
);
   import scb_pkg::*;

   localparam int AW = $clog2(MAX_COLUMNS);

   logic [63:0]   prod_ff, prod_in;
   logic          win_ff, win_in;
   logic [31:0]   diff;
   logic [64:0]   rounded;
   logic [48:0]   q;
   logic [10:0]   x11;
   logic [AW-1:0] addr_ff, addr_in;
   logic          ok_ff, ok_in;

   always_comb begin
      diff    = sample_time - window_left;
      win_in  = (sample_time >= window_left) && (sample_time <= window_right);
      prod_in = 64'(diff) * 64'(column_scale);
   end

   always_comb begin
      rounded = 65'(prod_ff) + 65'd32768;
      q       = rounded[64:16];
      x11     = 11'd2 + {3'b000, q[7:0]};
      ok_in   = win_ff && (screen_cols >= 8'd4)
                && (q <= {41'd0, screen_cols - 8'd3})
                && (x11 < 11'(MAX_COLUMNS));
      addr_in = x11[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.map1) begin
         prod_ff <= prod_in;
         win_ff  <= win_in;
      end
      if (ctl.map2) begin
         addr_ff <= addr_in;
         ok_ff   <= ok_in;
      end
   end

   assign col_addr = addr_ff;
   assign col_ok   = ok_ff;

endmodule

FILE: rtl/scb_lane.sv
// one channel lane: scaling, row mapping and min/max envelope store
module scb_lane #(
   parameter int MAX_COLUMNS = 256,
   parameter int CHANNELS    = 4,
   parameter int LANE        = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  scb_pkg::lane_ctl_type         ctl,
   input  logic signed [15:0]            sample,
   input  logic [15:0]                   gain,
   input  logic signed [15:0]            offset,
   input  logic [7:0]                    screen_rows,
   input  logic                          active,
   input  logic [$clog2(MAX_COLUMNS)-1:0] col_addr,
   input  logic                          col_ok,
   output logic                          rd_valid,
   output logic [7:0]                    rd_min,
   output logic [7:0]                    rd_max
);
   import scb_pkg::*;

   localparam int AW    = $clog2(MAX_COLUMNS);
   localparam int LSUM  = CHANNELS + 1;
   localparam int DIV   = 20 * LSUM;
   localparam int KMUL  = (LANE + 1) * 20;
   localparam int KOFF  = 10 * LSUM;
   localparam int SHIFT = 26;
   localparam logic [21:0] RECIP = 22'(((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));

   logic signed [33:0] gv, ot;
   logic signed [33:0] y24_ff, y24_in;
   logic [11:0]        rows9;
   logic signed [46:0] yr_ff, yr_in;
   logic signed [47:0] neg;
   logic signed [23:0] sh;
   logic [14:0]        kval;
   logic signed [25:0] n;
   logic [15:0]        n16_ff, n16_in;
   logic               lo_ff, lo_in;
   logic               big_ff, big_in;
   logic [37:0]        qprod;
   logic [7:0]         hi_lim, cand;
   logic [7:0]         row_ff, row_in;

   logic [7:0]             min_mem [MAX_COLUMNS];
   logic [7:0]             max_mem [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] valid_ff, valid_in;
   logic [7:0]             min_rd_ff, max_rd_ff;
   logic                   vrd_ff;
   logic [7:0]             new_min, new_max;
   logic                   wr_en;

   // y = gain*value + offset*2^12, units of 2^-24
   always_comb begin
      gv     = $signed({1'b0, gain}) * sample;
      ot     = $signed({offset, 12'h000});
      y24_in = gv + ot;
      rows9  = {1'b0, screen_rows, 3'b000} + {4'h0, screen_rows};
      yr_in  = y24_ff * $signed({1'b0, rows9});
   end

   // floor of the numerator over 2^24, then range flags for the divide by DIV
   always_comb begin
      neg    = 48'sd0 - yr_ff;
      sh     = neg[47:24];
      kval   = 15'(screen_rows * KMUL) + 15'(KOFF);
      n      = $signed({11'd0, kval}) + sh;
      lo_in  = n < $signed(26'(DIV));
      big_in = n >= $signed(26'(256 * DIV));
      n16_in = n[15:0];
   end

   // reciprocal divide, exact for the in-range numerators
   always_comb begin
      qprod  = 38'(n16_ff) * 38'(RECIP);
      hi_lim = screen_rows - 8'd1;
      cand   = lo_ff ? 8'd1 : qprod[SHIFT+7:SHIFT];
      if (big_ff || (cand > hi_lim)) begin
         row_in = hi_lim;
      end else begin
         row_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.map1) begin
         y24_ff <= y24_in;
      end
      if (ctl.map2) begin
         yr_ff <= yr_in;
      end
      if (ctl.map3) begin
         n16_ff <= n16_in;
         lo_ff  <= lo_in;
         big_ff <= big_in;
      end
      if (ctl.map4) begin
         row_ff <= row_in;
      end
   end

   // read-modify-write of the envelope
   always_comb begin
      wr_en   = ctl.update && active && col_ok;
      new_min = (!vrd_ff || (row_ff < min_rd_ff)) ? row_ff : min_rd_ff;
      new_max = (!vrd_ff || (row_ff > max_rd_ff)) ? row_ff : max_rd_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[col_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fetch) begin
         min_rd_ff <= min_mem[col_addr];
         max_rd_ff <= max_mem[col_addr];
      end
      if (wr_en) begin
         min_mem[col_addr] <= new_min;
         max_mem[col_addr] <= new_max;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vrd_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.fetch) begin
            vrd_ff <= valid_ff[col_addr];
         end
      end
   end

   assign rd_valid = vrd_ff;
   assign rd_min   = min_rd_ff;
   assign rd_max   = max_rd_ff;

endmodule

FILE: rtl/scb_checker.sv
// port-level checks for the envelope binner, bound to the top level
module scb_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input scb_pkg::req_type req_data,
   input logic             rsp_valid,
   input scb_pkg::rsp_type rsp_data,
   input logic             csr_we,
   input logic [2:0]       csr_index,
   input logic [63:0]      csr_wdata
);
   import scb_pkg::*;

   // a read request yields its result after the read and reply states
   a_read_reply: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.mode == MODE_READ) |=> ##2 rsp_valid)
      else $error("read request gave no result");

   a_read_echo: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.mode == MODE_READ)
      |=> ##2 (rsp_data.column_echo == $past(req_data.read_index, 3)))
      else $error("result column differs from requested column");

   a_reply_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !$past(rsp_valid))
      else $error("result without a request in flight");

   a_empty_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.occupied_mask[0]
      |-> (rsp_data.min_row_ch0 == 8'd0) && (rsp_data.max_row_ch0 == 8'd0))
      else $error("unoccupied channel reports rows");

endmodule

bind scope_column_envelope_binner_top scb_checker u_scb_checker (.*);
